FILE: design/srs_pkg.sv
// Shared types, constants and the control store of the systematic resampler.
package srs_pkg;

  localparam int unsigned WeightW = 32;
  localparam int unsigned TotalW  = 38;
  localparam int unsigned OffW    = 16;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned HalfW   = 19;
  localparam int unsigned PosW    = IdxW + OffW;
  localparam int unsigned ProdW   = PosW + HalfW;
  localparam int unsigned AccW    = ProdW + HalfW;
  localparam int unsigned RhsW    = TotalW + CountW;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned StepW   = 4;

  localparam logic [CountW-1:0] CountReset = 7'd64;

  localparam logic [StepW-1:0] StIdle    = 4'd0;
  localparam logic [StepW-1:0] StRhsLo   = 4'd1;
  localparam logic [StepW-1:0] StRhsHi   = 4'd2;
  localparam logic [StepW-1:0] StFull    = 4'd3;
  localparam logic [StepW-1:0] StLast    = 4'd4;
  localparam logic [StepW-1:0] StPosHi   = 4'd5;
  localparam logic [StepW-1:0] StCmp     = 4'd6;
  localparam logic [StepW-1:0] StQualify = 4'd7;
  localparam logic [StepW-1:0] StFlush   = 4'd8;

  typedef enum logic [1:0] {
    MS_CUM_LO,
    MS_CUM_HI,
    MS_POS_LO,
    MS_POS_HI
  } mul_sel_e;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_FULL,
    JC_LAST,
    JC_GT,
    JC_JUMP
  } jump_e;

  typedef struct packed {
    logic     in_rdy;
    mul_sel_e mul_sel;
    logic     acc_ld;
    logic     acc_add;
    logic     rhs_ld;
    logic     qualify;
    logic     flush;
  } ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic full;
    logic last;
    logic gt;
    logic stall;
  } stat_t;

  typedef struct packed {
    ctrl_t            ctrl;
    jump_e            jmp;
    logic [StepW-1:0] target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w        = '0;
    w.jmp    = JC_NEXT;
    w.target = StIdle;
    unique case (step)
      StIdle: begin
        w.ctrl.in_rdy = 1'b1;
        w.jmp         = JC_WAIT_IN;
      end
      StRhsLo: begin
        w.ctrl.mul_sel = MS_CUM_LO;
        w.ctrl.acc_ld  = 1'b1;
      end
      StRhsHi: begin
        w.ctrl.mul_sel = MS_CUM_HI;
        w.ctrl.rhs_ld  = 1'b1;
      end
      StFull: begin
        w.jmp    = JC_FULL;
        w.target = StFlush;
      end
      StLast: begin
        w.ctrl.mul_sel = MS_POS_LO;
        w.ctrl.acc_ld  = 1'b1;
        w.jmp          = JC_LAST;
        w.target       = StQualify;
      end
      StPosHi: begin
        w.ctrl.mul_sel = MS_POS_HI;
        w.ctrl.acc_add = 1'b1;
      end
      StCmp: begin
        w.jmp    = JC_GT;
        w.target = StFlush;
      end
      StQualify: begin
        w.ctrl.qualify = 1'b1;
        w.jmp          = JC_JUMP;
        w.target       = StFull;
      end
      StFlush: begin
        w.ctrl.flush = 1'b1;
        w.jmp        = JC_JUMP;
        w.target     = StIdle;
      end
      default: begin
        w.jmp    = JC_JUMP;
        w.target = StIdle;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: design/systematic_resampler_top.sv
// Top level of the systematic resampler: ports, count register, sequencer and datapath.
//
// Usage: weights of a run enter on the s_axis channel in particle order, each
// with the run total and a 16-bit offset; tuser marks the first weight (clears
// the running sum, index and slot, latches the offset) and tlast the last one
// (all slots still open take this index). For every weight the block emits
// zero or more (ancestor, slot) pairs on m_axis; tuser marks the last pair of a
// weight and tlast the pair that fills slot N-1.
// The particle count N is written on the cfg channel; the user must write it
// only while the block is idle, which the block itself does not enforce.
// 0 acts as 1 and values above MAX_PARTICLES as MAX_PARTICLES.
// The block takes one weight at a time; its steps are set by the microcode
// and the single 22x19 multiplier, which forms cum*N and slot position*total
// in two halves each.
// Results leave through a one-entry output register; a pending pair waits in
// the datapath, so the sequencer only halts when both are full and the
// receiver holds m_axis_tready low. No result is dropped or repeated.
// Reset clears the running state and sets N to 64; there is no clearing pass.
module systematic_resampler_top #(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [srs_pkg::CountW-1:0]          cfg_data_i,     // particle_count
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // weight[31:0], total_weight[69:32], offset[85:70], zero fill
  input  logic [srs_pkg::InDataW-1:0]         s_axis_tdata_i,
  input  logic                                s_axis_tuser_i, // first_item
  input  logic                                s_axis_tlast_i, // last_item
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // ancestor_index[5:0], slot[11:6], zero fill
  output logic [srs_pkg::OutDataW-1:0]        m_axis_tdata_o,
  output logic                                m_axis_tuser_o, // last_of_item
  output logic                                m_axis_tlast_o  // run_done
);

  logic [srs_pkg::CountW-1:0] count_q;
  srs_pkg::ctrl_t             ctrl;
  srs_pkg::stat_t             stat;
  logic [srs_pkg::IdxW-1:0]   anc;
  logic [srs_pkg::IdxW-1:0]   slot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= srs_pkg::CountReset;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  srs_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  srs_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .count_i        (count_q),
    .in_valid_i     (s_axis_tvalid_i),
    .weight_i       (s_axis_tdata_i[31:0]),
    .total_i        (s_axis_tdata_i[69:32]),
    .offset_i       (s_axis_tdata_i[85:70]),
    .first_i        (s_axis_tuser_i),
    .last_i         (s_axis_tlast_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .anc_o          (anc),
    .slot_o         (slot),
    .last_of_item_o (m_axis_tuser_o),
    .run_done_o     (m_axis_tlast_o)
  );

  assign s_axis_tready_o = ctrl.in_rdy;
  assign m_axis_tdata_o  = {{(srs_pkg::OutDataW - 2 * srs_pkg::IdxW){1'b0}}, slot, anc};

endmodule

FILE: design/srs_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
module srs_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srs_pkg::stat_t stat_i,
  output srs_pkg::ctrl_t ctrl_o
);

  logic [srs_pkg::StepW-1:0] step_q, step_d;
  srs_pkg::ucode_t           word;
  logic [srs_pkg::StepW-1:0] step_inc;

  assign word     = srs_pkg::ucode_rom(step_q);
  assign ctrl_o   = word.ctrl;
  assign step_inc = step_q + srs_pkg::StepW'(1);

  always_comb begin
    step_d = step_q;
    if (!stat_i.stall) begin
      unique case (word.jmp)
        srs_pkg::JC_NEXT:    step_d = step_inc;
        srs_pkg::JC_WAIT_IN: step_d = stat_i.in_acc ? step_inc : step_q;
        srs_pkg::JC_FULL:    step_d = stat_i.full ? word.target : step_inc;
        srs_pkg::JC_LAST:    step_d = stat_i.last ? word.target : step_inc;
        srs_pkg::JC_GT:      step_d = stat_i.gt ? word.target : step_inc;
        srs_pkg::JC_JUMP:    step_d = word.target;
        default:             step_d = srs_pkg::StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= srs_pkg::StIdle;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: design/srs_dp.sv
// Datapath: running state, shared multiplier, comparator and result register.
module srs_dp #(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srs_pkg::ctrl_t                 ctrl_i,
  output srs_pkg::stat_t                 stat_o,
  input  logic [srs_pkg::CountW-1:0]     count_i,
  input  logic                           in_valid_i,
  input  logic [srs_pkg::WeightW-1:0]    weight_i,
  input  logic [srs_pkg::TotalW-1:0]     total_i,
  input  logic [srs_pkg::OffW-1:0]       offset_i,
  input  logic                           first_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [srs_pkg::IdxW-1:0]       anc_o,
  output logic [srs_pkg::IdxW-1:0]       slot_o,
  output logic                           last_of_item_o,
  output logic                           run_done_o
);

  localparam logic [srs_pkg::CountW-1:0] MaxN = srs_pkg::CountW'(MAX_PARTICLES);
  localparam logic [srs_pkg::TotalW-1:0] SumMax = '1;

  logic [srs_pkg::CountW-1:0]  n;
  logic [srs_pkg::CountW-1:0]  n_m1;

  logic [srs_pkg::TotalW-1:0]  sum_q, sum_d;
  logic [srs_pkg::IdxW-1:0]    pidx_q, pidx_d;
  logic [srs_pkg::CountW-1:0]  slot_q, slot_d;
  logic [srs_pkg::OffW-1:0]    off_q, off_d;
  logic                        pend_q, pend_d;
  logic                        oval_q, oval_d;

  logic [srs_pkg::TotalW-1:0]  total_q;
  logic                        last_q;
  logic [srs_pkg::IdxW-1:0]    idx_q;
  logic [srs_pkg::IdxW-1:0]    pslot_q;
  logic [srs_pkg::AccW-1:0]    acc_q;
  logic [srs_pkg::RhsW-1:0]    rhs_q;
  logic [srs_pkg::IdxW-1:0]    oanc_q, oslot_q;
  logic                        olast_q, odone_q;

  logic                        in_acc;
  logic [srs_pkg::TotalW-1:0]  base_sum;
  logic [srs_pkg::IdxW-1:0]    base_pidx;
  logic [srs_pkg::TotalW:0]    sum_wide;
  logic [srs_pkg::TotalW-1:0]  cum;
  logic [srs_pkg::CountW-1:0]  pidx_inc;
  logic [srs_pkg::IdxW-1:0]    idx_new;

  logic [srs_pkg::PosW-1:0]    mul_a;
  logic [srs_pkg::HalfW-1:0]   mul_b;
  logic [srs_pkg::ProdW-1:0]   prod;
  logic [srs_pkg::AccW-1:0]    acc_sum;

  logic                        out_free;
  logic                        emit;
  logic                        stall;

  always_comb begin
    priority if (count_i == '0) n = srs_pkg::CountW'(1);
    else if (count_i > MaxN)    n = MaxN;
    else                        n = count_i;
  end
  assign n_m1 = n - srs_pkg::CountW'(1);

  assign in_acc    = ctrl_i.in_rdy & in_valid_i;
  assign base_sum  = first_i ? '0 : sum_q;
  assign base_pidx = first_i ? '0 : pidx_q;
  assign sum_wide  = {1'b0, base_sum} + {{(srs_pkg::TotalW + 1 - srs_pkg::WeightW){1'b0}}, weight_i};
  assign cum       = sum_wide[srs_pkg::TotalW] ? SumMax : sum_wide[srs_pkg::TotalW-1:0];
  assign pidx_inc  = {1'b0, base_pidx} + srs_pkg::CountW'(1);
  assign idx_new   = ({1'b0, base_pidx} > n_m1) ? n_m1[srs_pkg::IdxW-1:0] : base_pidx;

  always_comb begin
    unique case (ctrl_i.mul_sel)
      srs_pkg::MS_CUM_LO: begin
        mul_a = {{(srs_pkg::PosW - srs_pkg::CountW){1'b0}}, n};
        mul_b = sum_q[srs_pkg::HalfW-1:0];
      end
      srs_pkg::MS_CUM_HI: begin
        mul_a = {{(srs_pkg::PosW - srs_pkg::CountW){1'b0}}, n};
        mul_b = sum_q[srs_pkg::TotalW-1:srs_pkg::HalfW];
      end
      srs_pkg::MS_POS_LO: begin
        mul_a = {slot_q[srs_pkg::IdxW-1:0], off_q};
        mul_b = total_q[srs_pkg::HalfW-1:0];
      end
      srs_pkg::MS_POS_HI: begin
        mul_a = {slot_q[srs_pkg::IdxW-1:0], off_q};
        mul_b = total_q[srs_pkg::TotalW-1:srs_pkg::HalfW];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = srs_pkg::ProdW'(mul_a) * srs_pkg::ProdW'(mul_b);
  assign acc_sum = acc_q + {prod, {srs_pkg::HalfW{1'b0}}};

  assign out_free = !oval_q || out_ready_i;
  assign emit     = (ctrl_i.qualify || ctrl_i.flush) && pend_q;
  assign stall    = emit && !out_free;

  assign stat_o.in_acc = in_acc;
  assign stat_o.full   = (slot_q >= n);
  assign stat_o.last   = last_q;
  assign stat_o.gt     = {1'b0, acc_q} > {rhs_q, {srs_pkg::OffW{1'b0}}};
  assign stat_o.stall  = stall;

  always_comb begin
    sum_d  = sum_q;
    pidx_d = pidx_q;
    slot_d = slot_q;
    off_d  = off_q;
    pend_d = pend_q;
    oval_d = oval_q;
    if (oval_q && out_ready_i) oval_d = 1'b0;
    if (in_acc) begin
      sum_d  = cum;
      pidx_d = (pidx_inc <= n_m1) ? pidx_inc[srs_pkg::IdxW-1:0] : n_m1[srs_pkg::IdxW-1:0];
      if (first_i) begin
        slot_d = '0;
        off_d  = offset_i;
      end
    end
    if (!stall) begin
      if (emit) oval_d = 1'b1;
      if (ctrl_i.qualify) begin
        pend_d = 1'b1;
        slot_d = slot_q + srs_pkg::CountW'(1);
      end
      if (ctrl_i.flush) pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pidx_q <= '0;
      slot_q <= '0;
      off_q  <= '0;
      pend_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      pidx_q <= pidx_d;
      slot_q <= slot_d;
      off_q  <= off_d;
      pend_q <= pend_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      total_q <= total_i;
      last_q  <= last_i;
      idx_q   <= idx_new;
    end
    if (ctrl_i.acc_ld)  acc_q <= srs_pkg::AccW'(prod);
    if (ctrl_i.acc_add) acc_q <= acc_sum;
    if (ctrl_i.rhs_ld)  rhs_q <= acc_sum[srs_pkg::RhsW-1:0];
    if (!stall && ctrl_i.qualify) pslot_q <= slot_q[srs_pkg::IdxW-1:0];
    if (!stall && emit) begin
      oanc_q  <= idx_q;
      oslot_q <= pslot_q;
      olast_q <= ctrl_i.flush;
      odone_q <= ({1'b0, pslot_q} + srs_pkg::CountW'(1)) == n;
    end
  end

  assign out_valid_o    = oval_q;
  assign anc_o          = oanc_q;
  assign slot_o         = oslot_q;
  assign last_of_item_o = olast_q;
  assign run_done_o     = odone_q;

endmodule
